@@ hw/rtl/convex_hull_point_filter_assert.svh @@
// assertion macros used by the checker of the point filter
`ifndef CONVEX_HULL_POINT_FILTER_ASSERT_SVH
`define CONVEX_HULL_POINT_FILTER_ASSERT_SVH

// property checked on every clock edge outside reset
`define CHPF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every clock edge, reset included
`define CHPF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/chpf_pkg.sv @@
package chpf_pkg;

  // default table and list sizes
  localparam int unsigned DEF_MAX_PLANES = 64;
  localparam int unsigned DEF_MAX_POINTS = 256;

  // field widths
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned NORMAL_W = 17;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned OSLOT_W  = 8;
  localparam int unsigned TOTAL_W  = 9;
  localparam int unsigned PROD_W   = COORD_W + NORMAL_W;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned FRAC_W   = 16;

  // stream word widths
  localparam int unsigned IN_TDATA_W  = 192;
  localparam int unsigned OUT_TDATA_W = 120;

  // plane_count after reset
  localparam logic [COUNT_W-1:0] PLANE_COUNT_RESET = 7'd6;

  // operation codes carried on the input tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // one classified input word
  typedef struct packed {
    logic                       is_point;
    logic                       last;
    logic [SLOT_W-1:0]          slot;
    logic signed [NORMAL_W-1:0] nx;
    logic signed [NORMAL_W-1:0] ny;
    logic signed [NORMAL_W-1:0] nz;
    logic signed [COORD_W-1:0]  off;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic signed [COORD_W-1:0]  pz;
  } item_t;

  // one stored hull plane
  typedef struct packed {
    logic signed [NORMAL_W-1:0] nx;
    logic signed [NORMAL_W-1:0] ny;
    logic signed [NORMAL_W-1:0] nz;
    logic signed [COORD_W-1:0]  off;
  } plane_t;

  // back-end sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FINISH
  } back_state_e;

endpackage

@@ hw/rtl/chpf_front.sv @@
module chpf_front
  import chpf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                  s_axis_tuser_i,
  input  logic                  s_axis_tlast_i,
  output item_t                 head_o,
  output logic                  head_valid_o,
  input  logic                  pop_i
);

  item_t             entry_q [QUEUE_DEPTH];
  item_t             item_in;
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push;
  logic              pop;

  // unpack and classify the incoming word
  always_comb begin
    item_in.is_point = (s_axis_tuser_i == OP_TEST);
    item_in.last     = s_axis_tlast_i;
    item_in.slot     = s_axis_tdata_i[5:0];
    item_in.nx       = s_axis_tdata_i[22:6];
    item_in.ny       = s_axis_tdata_i[39:23];
    item_in.nz       = s_axis_tdata_i[56:40];
    item_in.off      = s_axis_tdata_i[88:57];
    item_in.px       = s_axis_tdata_i[120:89];
    item_in.py       = s_axis_tdata_i[152:121];
    item_in.pz       = s_axis_tdata_i[184:153];
  end

  // queue handshake
  assign s_axis_tready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign head_valid_o    = (cnt_q != '0);
  assign pop             = pop_i && head_valid_o;
  assign head_o          = entry_q[rd_ptr_q];

  // pointers and fill level
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

@@ hw/rtl/chpf_back.sv @@
module chpf_back
  import chpf_pkg::*;
#(
  parameter int unsigned MAX_PLANES = DEF_MAX_PLANES,
  parameter int unsigned MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [COUNT_W-1:0]     plane_count_i,
  input  item_t                  head_i,
  input  logic                   head_valid_i,
  output logic                   pop_o,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(MAX_PLANES);
  localparam int unsigned NW = $clog2(MAX_PLANES + 1);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  // plane table
  plane_t plane_mem [MAX_PLANES];

  back_state_e state_q, state_d;

  logic [NW-1:0]             n_planes;
  logic [NW-1:0]             iss_q;
  logic                      issue;
  logic                      emit;
  logic                      pipe_empty;
  logic                      out_free;
  logic                      wr_en;
  logic [AW-1:0]             wr_addr;

  // point held during its test
  logic signed [COORD_W-1:0] pt_x_q, pt_y_q, pt_z_q;
  logic                      pt_last_q;

  // dot-product pipeline
  logic                      v1_q, v2_q;
  plane_t                    rd_q;
  logic signed [PROD_W-1:0]  prod_x_q, prod_y_q, prod_z_q;
  logic signed [COORD_W-1:0] off2_q;
  logic signed [SUM_W-1:0]   dot_sum;
  logic signed [SUM_W-1:0]   dot_lim;
  logic                      outside_q;

  // kept counter and result
  logic [CW-1:0]             kept_q, kept_d;
  logic [CW-1:0]             slot_val;
  logic                      in_hull;
  logic                      take;

  logic                      m_valid_q;
  logic                      res_in_hull_q;
  logic                      res_last_q;
  logic [OSLOT_W-1:0]        res_slot_q;
  logic [TOTAL_W-1:0]        res_total_q;
  logic [COORD_W-1:0]        res_x_q, res_y_q, res_z_q;

  // planes in use, clipped to the table size
  assign n_planes = (32'(plane_count_i) > MAX_PLANES) ? NW'(MAX_PLANES) : NW'(plane_count_i);

  assign pipe_empty = !v1_q && !v2_q;
  assign out_free   = !m_valid_q || m_axis_tready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (head_valid_i && head_i.is_point) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (iss_q >= n_planes) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (pipe_empty && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_o = 1'b0;
    issue = 1'b0;
    emit  = 1'b0;
    unique case (state_q)
      ST_IDLE:   pop_o = head_valid_i;
      ST_ISSUE:  issue = (iss_q < n_planes);
      ST_FINISH: emit  = pipe_empty && out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // plane loads write the table, slots past the table are dropped
  assign wr_en   = pop_o && !head_i.is_point && (32'(head_i.slot) < MAX_PLANES);
  assign wr_addr = AW'(head_i.slot);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      plane_mem[wr_addr] <= '{nx: head_i.nx, ny: head_i.ny, nz: head_i.nz, off: head_i.off};
    end
  end

  // registered table read, one plane a cycle
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= plane_mem[iss_q[AW-1:0]];
    end
  end

  // latch the point and walk the plane index
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.is_point) begin
      pt_x_q    <= head_i.px;
      pt_y_q    <= head_i.py;
      pt_z_q    <= head_i.pz;
      pt_last_q <= head_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_q <= '0;
    end else if (pop_o) begin
      iss_q <= '0;
    end else if (issue) begin
      iss_q <= iss_q + NW'(1);
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  // exact products, Q17.32
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_x_q <= PROD_W'(pt_x_q) * PROD_W'(rd_q.nx);
      prod_y_q <= PROD_W'(pt_y_q) * PROD_W'(rd_q.ny);
      prod_z_q <= PROD_W'(pt_z_q) * PROD_W'(rd_q.nz);
      off2_q   <= rd_q.off;
    end
  end

  // sum and compare against the offset scaled to Q16.32
  assign dot_sum = SUM_W'(prod_x_q) + SUM_W'(prod_y_q) + SUM_W'(prod_z_q);
  assign dot_lim = SUM_W'(off2_q) <<< FRAC_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outside_q <= 1'b0;
    end else if (pop_o && head_i.is_point) begin
      outside_q <= 1'b0;
    end else if (v2_q && (dot_sum > dot_lim)) begin
      outside_q <= 1'b1;
    end
  end

  // kept counter, saturating, cleared after the last point
  assign in_hull  = !outside_q;
  assign take     = in_hull && (32'(kept_q) < MAX_POINTS);
  assign slot_val = take ? kept_q : '0;

  always_comb begin
    kept_d = take ? kept_q + CW'(1) : kept_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q <= '0;
    end else if (emit) begin
      kept_q <= pt_last_q ? '0 : kept_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_in_hull_q <= in_hull;
      res_last_q    <= pt_last_q;
      res_slot_q    <= OSLOT_W'(32'(slot_val));
      res_total_q   <= TOTAL_W'(32'(kept_d));
      res_x_q       <= pt_x_q;
      res_y_q       <= pt_y_q;
      res_z_q       <= pt_z_q;
    end
  end

  // the next point may be taken while this word still waits
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = res_in_hull_q;
  assign m_axis_tlast_o  = res_last_q;
  assign m_axis_tdata_o  = {7'd0, res_total_q, res_slot_q, res_z_q, res_y_q, res_x_q};

endmodule

@@ hw/rtl/convex_hull_point_filter.sv @@
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata plane or point, tuser operation, tlast last point
// m_axis    out  m_axis_tvalid/tready      tdata point and counts, tuser inside, tlast batch end
// cfg       in   cfg_we_i                  cfg_wdata_i plane_count
//
// a plane load is written to the table as it leaves the queue; a point is tested against
// min(plane_count, MAX_PLANES) planes, one plane a cycle through the single shared
// dot-product pipeline (table read, multipliers, add and compare)
// reset is asynchronous and active low; the plane table is not cleared
// a waiting result holds the back end before its next result; the two-word queue
// then fills and s_axis_tready drops
module convex_hull_point_filter
  import chpf_pkg::*;
#(
  parameter int unsigned MAX_PLANES = DEF_MAX_PLANES,
  parameter int unsigned MAX_POINTS = DEF_MAX_POINTS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [COUNT_W-1:0]     cfg_wdata_i,     // plane_count
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // plane_slot, normal_x, normal_y, normal_z, plane_offset, point_x, point_y, point_z
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,    // operation
  input  logic                   s_axis_tlast,    // last_point
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // kept_x, kept_y, kept_z, out_slot, kept_total
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tuser,    // inside_res
  output logic                   m_axis_tlast     // batch_end
);

  logic [COUNT_W-1:0] plane_count_q;
  item_t              head;
  logic               head_valid;
  logic               pop;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q <= PLANE_COUNT_RESET;
    end else if (cfg_we_i) begin
      plane_count_q <= cfg_wdata_i;
    end
  end

  // input side and queue
  chpf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .s_axis_tlast_i (s_axis_tlast),
    .head_o         (head),
    .head_valid_o   (head_valid),
    .pop_i          (pop)
  );

  // plane table, test pipeline and result register
  chpf_back #(
    .MAX_PLANES(MAX_PLANES),
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .plane_count_i  (plane_count_q),
    .head_i         (head),
    .head_valid_i   (head_valid),
    .pop_o          (pop),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser),
    .m_axis_tlast_o (m_axis_tlast)
  );

endmodule

@@ hw/rtl/chpf_checker.sv @@
`include "convex_hull_point_filter_assert.svh"

module chpf_checker
  import chpf_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast
);

  // a held result word keeps its payload
  `CHPF_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  // a point outside the hull takes no slot in the kept list
  `CHPF_ASSERT(a_outside_no_slot, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[103:96] == 8'd0, "outside point given a slot")

  // a reset seen low forces the offered result valid off
  `CHPF_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid, "result valid during reset")

endmodule

bind convex_hull_point_filter chpf_checker u_checker (.*);

@@ test/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chpf_pkg::*;

  // one result word as seen on m_axis
  typedef struct packed {
    logic               in_hull;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [OSLOT_W-1:0] oslot;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } hull_result_t;

  localparam int unsigned DRAIN_CYCLES = DEF_MAX_PLANES + 16;
  localparam logic signed [COORD_W-1:0] HUNDRED = 32'sd6553600;  // 100.0 in Q16.16
  localparam logic signed [COORD_W-1:0] C_MAX   = 32'sh7fffffff;
  localparam logic signed [COORD_W-1:0] C_MIN   = 32'sh80000000;
  localparam logic signed [NORMAL_W-1:0] N_ONE  = 17'sd65535;   // just below +1.0
  localparam logic signed [NORMAL_W-1:0] N_MONE = -17'sd65536;  // -1.0

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [COUNT_W-1:0]     cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   s_axis_tuser;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  // predictor state
  plane_t             hull_planes [DEF_MAX_PLANES];
  logic [COUNT_W-1:0] active_planes;
  int unsigned        kept_count;
  hull_result_t       pending_results [$];

  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned rx_hold_cycles;

  convex_hull_point_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #3ms;
    $display("== FAIL ==");
    $finish;
  end

  // plane loads update the table; points get a half-space test against it and update the kept count
  function automatic void filter_word(item_t w);
    hull_result_t r;
    int unsigned  n;
    logic         in_hull;
    longint       dot;
    longint       lim;
    if (w.is_point == OP_LOAD) begin
      hull_planes[w.slot] = '{nx: w.nx, ny: w.ny, nz: w.nz, off: w.off};
      return;
    end
    n = (active_planes > DEF_MAX_PLANES) ? DEF_MAX_PLANES : active_planes;
    in_hull = 1'b1;
    for (int p = 0; p < n; p++) begin
      dot = longint'($signed(hull_planes[p].nx)) * longint'($signed(w.px))
          + longint'($signed(hull_planes[p].ny)) * longint'($signed(w.py))
          + longint'($signed(hull_planes[p].nz)) * longint'($signed(w.pz));
      lim = longint'($signed(hull_planes[p].off)) * 65536;
      if (dot > lim) begin
        in_hull = 1'b0;
        break;
      end
    end
    r.oslot = '0;
    if (in_hull && kept_count < DEF_MAX_POINTS) begin
      r.oslot = OSLOT_W'(kept_count);
      kept_count++;
    end
    r.in_hull = in_hull;
    r.x       = w.px;
    r.y       = w.py;
    r.z       = w.pz;
    r.total   = TOTAL_W'(kept_count);
    r.last    = w.last;
    if (w.last) kept_count = 0;
    pending_results.push_back(r);
  endfunction

  function automatic item_t plane_word(int unsigned slot, logic signed [NORMAL_W-1:0] nx,
                                       logic signed [NORMAL_W-1:0] ny,
                                       logic signed [NORMAL_W-1:0] nz,
                                       logic signed [COORD_W-1:0] off);
    item_t w;
    w          = '0;
    w.is_point = OP_LOAD;
    w.slot     = SLOT_W'(slot);
    w.nx       = nx;
    w.ny       = ny;
    w.nz       = nz;
    w.off      = off;
    return w;
  endfunction

  function automatic item_t point_word(logic signed [COORD_W-1:0] px,
                                       logic signed [COORD_W-1:0] py,
                                       logic signed [COORD_W-1:0] pz, logic last);
    item_t w;
    w          = '0;
    w.is_point = OP_TEST;
    w.px       = px;
    w.py       = py;
    w.pz       = pz;
    w.last     = last;
    return w;
  endfunction

  // plane with any normal but an offset far enough out to keep small points inside
  function automatic item_t hull_plane(int unsigned slot);
    return plane_word(slot, NORMAL_W'($urandom), NORMAL_W'($urandom), NORMAL_W'($urandom),
                      COORD_W'($urandom_range(32'h3fffffff, 32'h01000000)));
  endfunction

  // point well within every hull plane
  function automatic item_t near_point(logic last);
    return point_word(int'($urandom_range(8388607)) - 4194304,
                      int'($urandom_range(8388607)) - 4194304,
                      int'($urandom_range(8388607)) - 4194304, last);
  endfunction

  function automatic item_t far_point(logic last);
    return point_word(COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom), last);
  endfunction

  // random word: mostly points, some hull planes, a few arbitrary planes in the upper slots
  function automatic item_t random_word();
    logic last;
    last = ($urandom_range(11) == 0);
    if ($urandom_range(99) < 20) begin
      if ($urandom_range(3) == 0)
        return plane_word($urandom_range(63, 32), NORMAL_W'($urandom), NORMAL_W'($urandom),
                          NORMAL_W'($urandom), COORD_W'($urandom));
      return hull_plane($urandom_range(63));
    end
    if ($urandom_range(9) < 7) return near_point(last);
    return far_point(last);
  endfunction

  // offer one word, with random gaps, and predict it once taken
  task automatic send_word(item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= w.is_point;
    s_axis_tlast  <= w.last;
    s_axis_tdata  <= {7'b0, w.pz, w.py, w.px, w.off, w.nz, w.ny, w.nx, w.slot};
    do @(posedge clk_i); while (!s_axis_tready);
    filter_word(w);
  endtask

  // sender stops until every expected result is back and the block is quiet
  task automatic wait_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_plane_count(logic [COUNT_W-1:0] value);
    wait_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    active_planes  = value;
  endtask

  // axis-aligned box of half-width 100, one face pushed out to the largest offset
  task automatic test_axis_box();
    send_word(plane_word(0, N_ONE, 0, 0, HUNDRED));
    send_word(plane_word(1, N_MONE, 0, 0, HUNDRED));
    send_word(plane_word(2, 0, N_ONE, 0, C_MAX));
    send_word(plane_word(3, 0, N_MONE, 0, HUNDRED));
    send_word(plane_word(4, 0, 0, N_ONE, HUNDRED));
    send_word(plane_word(5, 0, 0, N_MONE, HUNDRED));
    send_word(point_word(0, 0, 0, 1'b0));
    send_word(point_word(HUNDRED, 0, 0, 1'b0));
    // exactly on the -x face
    send_word(point_word(-HUNDRED, 0, 0, 1'b0));
    // one lsb beyond the -x face
    send_word(point_word(-HUNDRED - 1, 0, 0, 1'b0));
    send_word(point_word(0, C_MAX, 0, 1'b0));
    send_word(point_word(C_MIN, C_MIN, C_MIN, 1'b0));
    send_word(point_word(C_MAX, C_MAX, C_MAX, 1'b1));
    send_word(point_word(0, 0, HUNDRED, 1'b1));
  endtask

  // zero planes keeps everything, a single plane with the lowest offset keeps nothing
  task automatic test_count_extremes();
    set_plane_count(7'd0);
    send_word(point_word(C_MAX, C_MIN, C_MAX, 1'b0));
    send_word(point_word(C_MIN, C_MAX, C_MIN, 1'b1));
    send_word(plane_word(0, 0, 0, 0, C_MIN));
    set_plane_count(7'd1);
    send_word(point_word(0, 0, 0, 1'b0));
    send_word(point_word(C_MAX, 0, 0, 1'b1));
    send_word(plane_word(0, N_ONE, 0, 0, HUNDRED));
  endtask

  // whole table written, then the plane count above the table and at its size
  task automatic test_full_table();
    for (int i = 0; i < DEF_MAX_PLANES; i++) send_word(hull_plane(i));
    set_plane_count(7'd127);
    for (int i = 0; i < 6; i++) send_word(i < 4 ? near_point(1'b0) : far_point(i == 5));
    set_plane_count(7'd64);
    for (int i = 0; i < 6; i++) send_word(i < 4 ? near_point(1'b0) : far_point(i == 5));
  endtask

  // batch longer than the kept list: counter saturates, then clears on the last point
  task automatic test_list_full();
    set_plane_count(7'd0);
    for (int i = 0; i < DEF_MAX_POINTS + 2; i++) send_word(far_point(i == DEF_MAX_POINTS + 1));
    send_word(near_point(1'b1));
  endtask

  // receiver holds off for a long stretch while points keep coming
  task automatic test_stall();
    set_plane_count(7'd4);
    rx_hold_cycles = 300;
    for (int i = 0; i < 12; i++) send_word(near_point(i == 11));
    wait_results();
  endtask

  task automatic test_random();
    logic [COUNT_W-1:0] count_pick;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 68 : 0;
      recv_idle_pct = (phase == 0) ? 68 : (phase == 1) ? 37 : 0;
      for (int chunk = 0; chunk < 3; chunk++) begin
        case ($urandom_range(4))
          0:       count_pick = 7'd0;
          1:       count_pick = 7'd1;
          2:       count_pick = COUNT_W'($urandom_range(32, 2));
          3:       count_pick = 7'd64;
          default: count_pick = 7'd127;
        endcase
        set_plane_count(count_pick);
        for (int i = 0; i < 4; i++) send_word(random_word());
      end
    end
    wait_results();
  endtask

  // receiver side
  always @(posedge clk_i) begin
    if (rx_hold_cycles > 0) begin
      rx_hold_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // compare each taken result word with the oldest prediction
  always @(posedge clk_i) begin
    hull_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with none expected");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("inside_res", want.in_hull, m_axis_tuser);
        check_field("kept_x", want.x, m_axis_tdata[31:0]);
        check_field("kept_y", want.y, m_axis_tdata[63:32]);
        check_field("kept_z", want.z, m_axis_tdata[95:64]);
        check_field("out_slot", want.oslot, m_axis_tdata[103:96]);
        check_field("kept_total", want.total, m_axis_tdata[112:104]);
        check_field("batch_end", want.last, m_axis_tlast);
      end
    end
  end

  // stimulus
  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_LOAD;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    fail_count     = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    rx_hold_cycles = 0;
    kept_count     = 0;
    active_planes  = PLANE_COUNT_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_axis_box();
    test_count_extremes();
    test_full_table();
    test_list_full();
    test_stall();
    test_random();

    wait_results();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
